### hw/rtl/sha1_pkg.sv
`default_nettype none
package sha1_pkg;
	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam int WORD_W = 32;
	localparam int SCHED_DEPTH = 16;
	localparam int SCHED_AW = 4;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction
endpackage
`default_nettype wire

### hw/rtl/sha1_stream_hasher_unit.sv
`default_nettype none
// SHA-1 hasher over a byte stream. Each input beat carries tdata (message
// byte), tuser (byte valid) and tlast (end of message). Bytes are packed into
// 32-bit words and written to a 16-word schedule memory; byte beats are taken
// back to back while the unit is idle. Once the 64th byte of a block is taken,
// the input stalls through a setup step, 80 rounds at one round per cycle and
// a state update; no byte is taken while the round loop runs. The schedule
// word W[t] comes from memory for t < 16 and from a 16-word shift line of
// recent schedule words afterward. On end of message the pad block is filled
// one word slot per cycle (slots that already hold message bytes are left as
// they are), and then compressed. When the length does not fit behind the pad
// byte, a second pad block follows and is filled and compressed the same way.
// The five digest words then leave as output beats, word A first, tlast on the
// fifth. Input is stalled while a block or the digest is in progress.
module sha1_stream_hasher_unit
	import sha1_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
	input  wire logic        s_tuser,   // byte_valid
	input  wire logic        s_tlast,   // last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,   // word_index[2:0], digest_word[34:3], zero fill
	output logic             m_tlast    // last_word
);
	typedef enum logic [2:0] {ST_IDLE, ST_PAD, ST_PRE, ST_ROUND, ST_FIN, ST_OUT}
		state_t;

	state_t      state_q;
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [63:0] cnt_q;
	logic [31:0] acc_q;
	logic [6:0]  rnd_q;
	logic        two_q;       // a further pad block follows
	logic        final_q;     // current block ends the message
	logic [3:0]  pw_q;        // pad word index
	logic [2:0]  oi_q;
	logic [31:0] tap_q [16];  // last 16 schedule words
	// Tail already placed once the overflow block is written.
	logic        tail_done_q;

	logic                we;
	logic [SCHED_AW-1:0] waddr, raddr;
	logic [31:0]         wdata, rdata;

	sha1_ram #(.WIDTH(WORD_W), .DEPTH(SCHED_DEPTH)) u_sched (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [5:0]  pos;
	logic [31:0] wnew, wt, f, k, t;
	assign pos = cnt_q[8:3];
	assign wnew = rotl(tap_q[13] ^ tap_q[8] ^ tap_q[2] ^ tap_q[0], 5'd1);
	assign wt = (rnd_q < 7'd16) ? rdata : wnew;

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q); k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q; k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q; k = K3;
		end
	end
	assign t = rotl(a_q, 5'd5) + f + e_q + wt + k;

	// The byte being merged into the current word.
	logic [31:0] acc_n;
	always_comb begin
		acc_n = acc_q;
		unique case (pos[1:0])
			2'd0: acc_n = {s_tdata, 24'd0};
			2'd1: acc_n[23:16] = s_tdata;
			2'd2: acc_n[15:8] = s_tdata;
			2'd3: acc_n[7:0] = s_tdata;
			default: acc_n = acc_q;
		endcase
	end

	// Pad words: tail word with 0x80, zeros, then the length.
	logic [31:0] pad_w, tail_w;
	always_comb begin
		tail_w = acc_q;
		unique case (pos[1:0])
			2'd0: tail_w = {PAD_BYTE, 24'd0};
			2'd1: tail_w = {acc_q[31:24], PAD_BYTE, 16'd0};
			2'd2: tail_w = {acc_q[31:16], PAD_BYTE, 8'd0};
			2'd3: tail_w = {acc_q[31:8], PAD_BYTE};
			default: tail_w = acc_q;
		endcase
	end
	always_comb begin
		if (!two_q && pw_q == 4'd14) pad_w = cnt_q[63:32];
		else if (!two_q && pw_q == 4'd15) pad_w = cnt_q[31:0];
		else if (!tail_done_q && pw_q == pos[5:2]) pad_w = tail_w;
		else pad_w = 32'd0;
	end

	assign s_tready = (state_q == ST_IDLE);
	logic take;
	assign take = s_tvalid && s_tready;

	always_comb begin
		we = 1'b0; waddr = pos[5:2]; wdata = acc_n;
		raddr = rnd_q[3:0];
		if (state_q == ST_IDLE) begin
			we = take && s_tuser && pos[1:0] == 2'd3;
		end else if (state_q == ST_PAD) begin
			// Words ahead of the tail word still hold message bytes.
			we = tail_done_q || (pw_q >= pos[5:2]);
			waddr = pw_q; wdata = pad_w;
		end
		if (state_q == ST_PRE) raddr = 4'd0;
		else if (state_q == ST_ROUND) raddr = rnd_q[3:0] + 4'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0;
			for (int i = 0; i < 16; i++) tap_q[i] <= '0;
			cnt_q <= '0; acc_q <= '0; rnd_q <= '0; two_q <= 1'b0; final_q <= 1'b0;
			pw_q <= '0; oi_q <= '0; m_tvalid <= 1'b0; tail_done_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (take) begin
					if (s_tuser) begin
						acc_q <= acc_n;
						cnt_q <= cnt_q + 64'd8;
					end
					if (s_tuser && pos == 6'd63) begin
						// block full; a pending end mark pads after it
						two_q <= s_tlast;
						state_q <= ST_PRE;
						pw_q <= 4'd0;
					end else if (s_tlast) begin
						pw_q <= 4'd0;
						state_q <= ST_PAD;
						// with the byte merged, tail position uses pos+1
						two_q <= ((s_tuser ? pos + 6'd1 : pos) > 6'd55);
					end
				end
				ST_PAD: begin
					pw_q <= pw_q + 4'd1;
					if (pw_q == 4'd15) begin
						state_q <= ST_PRE;
						// A pad block that carries the length is the final one.
						if (two_q) begin
							two_q <= 1'b0;
							tail_done_q <= 1'b1;
						end else begin
							final_q <= 1'b1;
						end
					end
				end
				ST_PRE: begin
					a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2];
					d_q <= h_q[3]; e_q <= h_q[4];
					rnd_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					for (int i = 0; i < 15; i++) tap_q[i] <= tap_q[i+1];
					tap_q[15] <= wt;
					e_q <= d_q; d_q <= c_q; c_q <= rotl(b_q, 5'd30);
					b_q <= a_q; a_q <= t;
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd79) state_q <= ST_FIN;
				end
				ST_FIN: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					pw_q <= 4'd0;
					if (final_q) begin
						state_q <= ST_OUT; oi_q <= '0; m_tvalid <= 1'b1;
					end else if (two_q || tail_done_q) begin
						// padding still owed: tail block or length block
						two_q <= 1'b0;
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: if (m_tready) begin
					oi_q <= oi_q + 3'd1;
					if (oi_q == 3'd4) begin
						m_tvalid <= 1'b0;
						state_q <= ST_IDLE;
						cnt_q <= '0;
						final_q <= 1'b0;
						tail_done_q <= 1'b0;
						h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2;
						h_q[3] <= H3; h_q[4] <= H4;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic [31:0] dsel;
	always_comb begin
		unique case (oi_q)
			3'd0: dsel = h_q[0];
			3'd1: dsel = h_q[1];
			3'd2: dsel = h_q[2];
			3'd3: dsel = h_q[3];
			default: dsel = h_q[4];
		endcase
	end
	assign m_tdata = {5'd0, dsel, oi_q};
	assign m_tlast = (oi_q == 3'd4);
endmodule
`default_nettype wire

### hw/rtl/sha1_ram.sv
`default_nettype none
module sha1_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### hw/rtl/sha1_checker.sv
`default_nettype none
module sha1_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic        m_tlast
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken during digest");
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[2:0] == 3'd4) else $error("bad last index");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output not held");
endmodule

bind sha1_stream_hasher_unit sha1_checker u_chk (.*);
`default_nettype wire

### dv/sha1_stream_hasher_unit_test.sv
`default_nettype none
module sha1_stream_hasher_unit_test
	import sha1_pkg::*;
();

	// One expected digest word as it should leave the master side.
	typedef struct packed {
		logic [2:0]  word_index;
		logic [31:0] digest_word;
		logic        last_word;
	} digest_beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // data_byte[7:0]
	logic        s_tuser;   // byte_valid
	logic        s_tlast;   // last
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // word_index[2:0], digest_word[34:3], zero fill
	logic        m_tlast;   // last_word

	sha1_stream_hasher_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// Predictor state: chaining words, the block being filled and the bit count.
	logic [31:0]  chain_words [5];
	logic [7:0]   block_bytes [64];
	logic [63:0]  msg_bits;
	digest_beat_t digest_queue [$];

	int  errors = 0;
	int  sent_beats = 0;
	int  messages = 0;
	int  digest_beats_seen = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  hold_off_cycles = 0;
	int  quiet_cycles = 0;
	bit  done = 1'b0;

	// Largest stretch with no beat in either direction: a long receive hold-off
	// plus two blocks and the pad words, taken several times over.
	localparam int QUIET_LIMIT = 20000;

	function automatic logic [31:0] rot_left(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	task automatic compress_block();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
				block_bytes[4*i+3]};
		for (int i = 16; i < 80; i++)
			w[i] = rot_left(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = chain_words[0]; b = chain_words[1]; c = chain_words[2];
		d = chain_words[3]; e = chain_words[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d); k = K0;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = K1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = K2;
			end else begin
				f = b ^ c ^ d; k = K3;
			end
			t = rot_left(a, 5) + f + e + w[i] + k;
			e = d; d = c; c = rot_left(b, 30); b = a; a = t;
		end
		chain_words[0] += a; chain_words[1] += b; chain_words[2] += c;
		chain_words[3] += d; chain_words[4] += e;
	endtask

	task automatic restart_hash();
		chain_words = '{H0, H1, H2, H3, H4};
		msg_bits = '0;
	endtask

	// Advances the predictor by one accepted beat and queues any digest words.
	task automatic hash_beat(input logic [7:0] data, input logic has_byte,
			input logic ends_msg);
		int pos;
		logic [63:0] len;
		if (has_byte) begin
			pos = int'(msg_bits[8:3]);
			block_bytes[pos] = data;
			msg_bits += 64'd8;
			if (pos == 63)
				compress_block();
		end
		if (!ends_msg)
			return;
		len = msg_bits;
		pos = int'(msg_bits[8:3]);
		block_bytes[pos] = PAD_BYTE;
		pos++;
		// When the length no longer fits behind the pad byte, an extra block goes.
		if (pos > 56) begin
			while (pos < 64) block_bytes[pos++] = 8'h00;
			compress_block();
			pos = 0;
		end
		while (pos < 56) block_bytes[pos++] = 8'h00;
		for (int i = 0; i < 8; i++)
			block_bytes[56+i] = len[63-8*i -: 8];
		compress_block();
		for (int i = 0; i < 5; i++)
			digest_queue.push_back('{word_index: 3'(i), digest_word: chain_words[i],
				last_word: (i == 4)});
		messages++;
		restart_hash();
	endtask

	// Offers one beat, waits for acceptance and updates the predictor. Valid
	// stays high across back-to-back beats; gaps are inserted only on request.
	task automatic send_beat(input logic [7:0] data, input logic has_byte,
			input logic ends_msg);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= has_byte;
		s_tlast  <= ends_msg;
		do @(posedge clk); while (!s_tready);
		hash_beat(data, has_byte, ends_msg);
		sent_beats++;
		@(negedge clk);
	endtask

	task automatic send_message(input int nbytes);
		for (int i = 0; i < nbytes; i++) begin
			// Occasional beats with no byte must not change the hash.
			if ($urandom_range(15) == 0)
				send_beat(8'($urandom), 1'b0, 1'b0);
			send_beat(8'($urandom), 1'b1, (i == nbytes - 1));
		end
		if (nbytes == 0)
			send_beat(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (digest_queue.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	// Empty message, lone marker, all data byte extremes and a byteless marker.
	// test_block_edges covers 55 bytes (one pad block) and 56 (two pad blocks).
	task automatic test_directed();
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'hFF, 1'b0, 1'b0);
		send_beat(8'hA5, 1'b0, 1'b1);
		send_beat(8'h00, 1'b1, 1'b1);
		send_beat(8'hFF, 1'b1, 1'b0);
		send_beat(8'h55, 1'b1, 1'b0);
		send_beat(8'hAA, 1'b1, 1'b1);
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(8'h62, 1'b1, 1'b0);
		send_beat(8'h63, 1'b1, 1'b0);
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'hFF, 1'b0, 1'b1);
		drain();
	endtask

	task automatic test_block_edges();
		int sizes [4] = '{55, 56, 63, 64};
		foreach (sizes[i])
			send_message(sizes[i]);
		drain();
	endtask

	// The bit counter wraps modulo 2^64; bringing it near the top takes far
	// too many bytes, so the predictor side is exercised only through the
	// natural count here.
	task automatic test_random(input int budget);
		int start_beats;
		start_beats = sent_beats;
		while (sent_beats - start_beats < budget) begin
			// Mostly short messages, now and then one near or past a block boundary.
			if ($urandom_range(9) == 0)
				send_message($urandom_range(56, 70));
			else
				send_message($urandom_range(0, 20));
		end
		drain();
	endtask

	// The receiver holds off while the sender keeps offering messages, so the
	// output fills and the input stalls.
	task automatic test_backpressure();
		hold_off_cycles = 600;
		send_message(3);
		send_message(5);
		send_message(1);
		drain();
	endtask

	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		digest_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			digest_beats_seen++;
			if (digest_queue.size() == 0) begin
				$error("digest word with none expected: %h", m_tdata);
				errors++;
			end else begin
				want = digest_queue.pop_front();
				if (m_tdata[2:0] !== want.word_index) begin
					$error("word_index expected %0d got %0d", want.word_index,
						m_tdata[2:0]);
					errors++;
				end
				if (m_tdata[34:3] !== want.digest_word) begin
					$error("digest_word expected %h got %h", want.digest_word,
						m_tdata[34:3]);
					errors++;
				end
				if (m_tlast !== want.last_word) begin
					$error("last_word expected %0d got %0d", want.last_word, m_tlast);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no beat accepted on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("sha1_stream_hasher_unit regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		s_tlast  = 1'b0;
		m_tready = 1'b0;
		restart_hash();
		foreach (block_bytes[i]) block_bytes[i] = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 34; recv_idle_pct = 78;
		test_directed();
		test_block_edges();
		test_random(40);
		send_idle_pct = 78; recv_idle_pct = 34;
		test_random(40);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_backpressure();
		test_random(40);

		done = 1'b1;
		$display("Covered %0d input beats over %0d messages, %0d digest words checked,",
			sent_beats, messages, digest_beats_seen);
		$display("including empty messages, block edges, idle mixes and output hold-off.");
		if (errors == 0 && digest_queue.size() == 0)
			$display("sha1_stream_hasher_unit regression: pass");
		else
			$display("sha1_stream_hasher_unit regression: fail");
		$finish;
	end
endmodule
`default_nettype wire

### sim.f
hw/rtl/sha1_pkg.sv
hw/rtl/sha1_ram.sv
hw/rtl/sha1_stream_hasher_unit.sv
hw/rtl/sha1_checker.sv
dv/sha1_stream_hasher_unit_test.sv
